[rtl/i2cras_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cras_pkg
// Shared types, codes and constants of the I2C register access sequencer.
// ----------------------------------------------------------------------------
package i2cras_pkg;

  localparam int unsigned WAIT_W        = 20;
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned MAX_RES       = 3;
  localparam int unsigned RESN_W        = 2;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QPTR_W        = 2;
  localparam int unsigned QCNT_W        = 3;

  localparam logic [WAIT_W-1:0]  TIMEOUT_RESET    = 20'd100000;
  localparam logic [WAIT_W-1:0]  TIMEOUT_MIN      = 20'd1;
  localparam logic [PADDR_W-1:0] ADDR_TIMEOUT     = 3'd0;

  typedef enum logic {
    OP_COMMAND = 1'b0,
    OP_SAMPLE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_MODIFY   = 2'd2,
    CMD_READ_BIT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_WRITE    = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_ACK      = 3'd4,
    ACT_NACK     = 3'd5,
    ACT_CLR_NACK = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_ADDR     = 4'd2,
    PH_TXE_REG  = 4'd3,
    PH_TXD_REG  = 4'd4,
    PH_TXE_DATA = 4'd5,
    PH_TXD_DATA = 4'd6,
    PH_RSTART   = 4'd7,
    PH_RADDR    = 4'd8,
    PH_RX       = 4'd9
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] command;
    logic [6:0] target_addr;
    logic [7:0] reg_index;
    logic [7:0] data_or_mask;
    logic       set_bits;
    logic       start_sent;
    logic       address_acked;
    logic       nack_seen;
    logic       tx_empty;
    logic       rx_ready;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_value;
    logic       last;
  } res_t;

  function automatic res_t mk_res(act_t act, logic [7:0] tx, logic done,
                                  status_t st, logic [7:0] val);
    res_t r;
    r.action     = act;
    r.tx_byte    = tx;
    r.done_res   = done;
    r.status     = st;
    r.read_value = val;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

[rtl/i2cras_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cras_fsm
// Transaction phase machine: takes one request per cycle while accept is high and
// produces the list of peripheral actions (up to three) that the request causes.
// ----------------------------------------------------------------------------
module i2cras_fsm import i2cras_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  req_t                   req,
  input  logic [WAIT_W-1:0]      limit,
  output res_t [MAX_RES-1:0]     res,
  output logic [RESN_W-1:0]      res_n
);

  phase_t            phase_r, phase_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [6:0]        dev_r, dev_nxt;
  logic [7:0]        reg_r, reg_nxt;
  logic [7:0]        opnd_r, opnd_nxt;
  logic              set_r, set_nxt;
  logic [7:0]        rbyte_r, rbyte_nxt;
  logic              wpass_r, wpass_nxt;

  logic [WAIT_W-1:0] lim_eff;
  logic [WAIT_W-1:0] wait_inc;
  logic              miss;
  logic              writing;
  logic              is_cmd;
  logic [7:0]        modified;
  logic [7:0]        read_val;
  logic              rd_phase;

  assign lim_eff  = (limit == '0) ? TIMEOUT_MIN : limit;
  assign wait_inc = wait_r + TIMEOUT_MIN;
  assign miss     = (wait_inc >= lim_eff);
  assign writing  = (cmd_r == CMD_WRITE) || wpass_r;
  assign is_cmd   = (req.opcode == OP_COMMAND);
  assign modified = set_r ? (req.rx_byte | opnd_r) : (req.rx_byte & ~opnd_r);
  assign read_val = (cmd_r == CMD_READ_BIT) ? {7'd0, |(req.rx_byte & opnd_r)}
                                            : req.rx_byte;
  assign rd_phase = (phase_r == PH_RSTART);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    cmd_nxt   = cmd_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    opnd_nxt  = opnd_r;
    set_nxt   = set_r;
    rbyte_nxt = rbyte_r;
    wpass_nxt = wpass_r;
    if (accept) begin
      if (is_cmd) begin
        if (phase_r == PH_IDLE) begin
          cmd_nxt   = cmd_t'(req.command);
          dev_nxt   = req.target_addr;
          reg_nxt   = req.reg_index;
          opnd_nxt  = req.data_or_mask;
          set_nxt   = req.set_bits;
          rbyte_nxt = 8'd0;
          wpass_nxt = 1'b0;
          phase_nxt = PH_START;
          wait_nxt  = '0;
        end
      end else begin
        case (phase_r)
          PH_START, PH_RSTART: begin
            if (req.start_sent) begin
              phase_nxt = rd_phase ? PH_RADDR : PH_ADDR;
              wait_nxt  = '0;
            end else if (miss) begin
              phase_nxt = PH_IDLE;
            end else begin
              wait_nxt = wait_inc;
            end
          end
          PH_ADDR, PH_RADDR: begin
            if (req.nack_seen) begin
              phase_nxt = PH_IDLE;
            end else if (req.address_acked) begin
              phase_nxt = (phase_r == PH_ADDR) ? PH_TXE_REG : PH_RX;
              wait_nxt  = '0;
            end else if (miss) begin
              phase_nxt = PH_IDLE;
            end else begin
              wait_nxt = wait_inc;
            end
          end
          PH_TXE_REG, PH_TXD_REG, PH_TXE_DATA, PH_TXD_DATA: begin
            if (req.tx_empty) begin
              wait_nxt = '0;
              case (phase_r)
                PH_TXE_REG:  phase_nxt = PH_TXD_REG;
                PH_TXD_REG:  phase_nxt = writing ? PH_TXE_DATA : PH_RSTART;
                PH_TXE_DATA: phase_nxt = PH_TXD_DATA;
                default:     phase_nxt = PH_IDLE;
              endcase
            end else if (miss) begin
              phase_nxt = PH_IDLE;
            end else begin
              wait_nxt = wait_inc;
            end
          end
          PH_RX: begin
            if (req.rx_ready) begin
              wait_nxt = '0;
              if (cmd_r == CMD_MODIFY) begin
                rbyte_nxt = modified;
                phase_nxt = PH_START;
                wpass_nxt = 1'b1;
              end else begin
                rbyte_nxt = req.rx_byte;
                phase_nxt = PH_IDLE;
              end
            end else if (miss) begin
              phase_nxt = PH_IDLE;
            end else begin
              wait_nxt = wait_inc;
            end
          end
          PH_IDLE: ;
          default: phase_nxt = PH_IDLE;
        endcase
      end
      if (phase_nxt == PH_IDLE && phase_r != PH_IDLE) begin
        wait_nxt  = '0;
        wpass_nxt = 1'b0;
      end
    end
  end

  // action list
  always_comb begin
    res   = '0;
    res_n = '0;
    if (accept) begin
      if (is_cmd) begin
        if (phase_r == PH_IDLE) begin
          res[0] = mk_res(ACT_START, 8'd0, 1'b0, ST_OK, 8'd0);
          res_n  = 2'd1;
        end
      end else begin
        case (phase_r)
          PH_START, PH_RSTART: begin
            if (req.start_sent) begin
              res[0] = mk_res(ACT_WRITE, {dev_r, rd_phase}, 1'b0, ST_OK, 8'd0);
              res_n  = 2'd1;
            end else if (miss) begin
              res[0] = mk_res(ACT_NONE, 8'd0, 1'b1, ST_TIMEOUT, 8'd0);
              res_n  = 2'd1;
            end
          end
          PH_ADDR, PH_RADDR: begin
            if (req.nack_seen) begin
              res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ST_OK, 8'd0);
              res[1] = mk_res(ACT_CLR_NACK, 8'd0, 1'b1, ST_NACK, 8'd0);
              res_n  = 2'd2;
            end else if (req.address_acked) begin
              if (phase_r == PH_RADDR) begin
                res[0] = mk_res(ACT_NACK, 8'd0, 1'b0, ST_OK, 8'd0);
                res_n  = 2'd1;
              end
            end else if (miss) begin
              res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ST_OK, 8'd0);
              res[1] = mk_res(ACT_CLR_NACK, 8'd0, 1'b1, ST_TIMEOUT, 8'd0);
              res_n  = 2'd2;
            end
          end
          PH_TXE_REG, PH_TXD_REG, PH_TXE_DATA, PH_TXD_DATA: begin
            if (req.tx_empty) begin
              case (phase_r)
                PH_TXE_REG: begin
                  res[0] = mk_res(ACT_WRITE, reg_r, 1'b0, ST_OK, 8'd0);
                  res_n  = 2'd1;
                end
                PH_TXD_REG: begin
                  if (!writing) begin
                    res[0] = mk_res(ACT_START, 8'd0, 1'b0, ST_OK, 8'd0);
                    res_n  = 2'd1;
                  end
                end
                PH_TXE_DATA: begin
                  res[0] = mk_res(ACT_WRITE, wpass_r ? rbyte_r : opnd_r, 1'b0,
                                  ST_OK, 8'd0);
                  res_n  = 2'd1;
                end
                default: begin
                  res[0] = mk_res(ACT_STOP, 8'd0, 1'b1, ST_OK, 8'd0);
                  res_n  = 2'd1;
                end
              endcase
            end else if (miss) begin
              res[0] = mk_res(ACT_NONE, 8'd0, 1'b1, ST_TIMEOUT, 8'd0);
              res_n  = 2'd1;
            end
          end
          PH_RX: begin
            if (req.rx_ready) begin
              res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ST_OK, 8'd0);
              if (cmd_r == CMD_MODIFY) begin
                res[1] = mk_res(ACT_ACK, 8'd0, 1'b0, ST_OK, 8'd0);
                res[2] = mk_res(ACT_START, 8'd0, 1'b0, ST_OK, 8'd0);
                res_n  = 2'd3;
              end else begin
                res[1] = mk_res(ACT_ACK, 8'd0, 1'b1, ST_OK, read_val);
                res_n  = 2'd2;
              end
            end else if (miss) begin
              res[0] = mk_res(ACT_STOP, 8'd0, 1'b0, ST_OK, 8'd0);
              res[1] = mk_res(ACT_ACK, 8'd0, 1'b1, ST_TIMEOUT, 8'd0);
              res_n  = 2'd2;
            end
          end
          default: ;
        endcase
      end
      case (res_n)
        2'd1:    res[0].last = 1'b1;
        2'd2:    res[1].last = 1'b1;
        2'd3:    res[2].last = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      cmd_r   <= CMD_WRITE;
      dev_r   <= '0;
      reg_r   <= '0;
      opnd_r  <= '0;
      set_r   <= 1'b0;
      rbyte_r <= '0;
      wpass_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      cmd_r   <= cmd_nxt;
      dev_r   <= dev_nxt;
      reg_r   <= reg_nxt;
      opnd_r  <= opnd_nxt;
      set_r   <= set_nxt;
      rbyte_r <= rbyte_nxt;
      wpass_r <= wpass_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_n != '0 && (res[0].done_res || res[1].done_res || res[2].done_res))
    |=> phase_r == PH_IDLE)
    else $error("phase not idle after a finishing action");

  a_wpass_modify: assert property (@(posedge clk) disable iff (!rst_n)
    wpass_r |-> cmd_r == CMD_MODIFY)
    else $error("write pass flagged outside a modify command");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> (wait_r == '0 && !wpass_r))
    else $error("idle with stale wait count or write pass");
`endif

endmodule

[rtl/i2cras_resq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cras_resq
// Four-entry action queue: takes up to three actions in one cycle and hands
// them out one per cycle on the result channel while out_stall is low.
// ----------------------------------------------------------------------------
module i2cras_resq import i2cras_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  res_t [MAX_RES-1:0]     push_res,
  input  logic [RESN_W-1:0]      push_n,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output res_t                   out_res
);

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] tail;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign tail      = head_r + cnt_r[QPTR_W-1:0];
  // room for a full three-action burst once this cycle's pop is done
  assign full      = (cnt_r > QCNT_W'(2)) || (cnt_r == QCNT_W'(2) && !pop);
  assign head_nxt  = head_r + QPTR_W'(pop);
  assign cnt_nxt   = cnt_r - QCNT_W'(pop) + QCNT_W'(push_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RESN_W'(k) < push_n) begin
        q_r[tail + QPTR_W'(k)] <= push_res[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("action queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != '0 |-> (cnt_r - QCNT_W'(pop)) <= QCNT_W'(1))
    else $error("actions pushed without room");
`endif

endmodule

[rtl/i2c_register_access_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_sequencer
// Sequences I2C master register write, read, read-modify-write and bit read
// transactions, one peripheral status sample per request.
//
//   channel   direction  handshake             payload
//   in_*      request    in_valid / in_stall   opcode, command, addresses,
//                                              operand, status flags, rx_byte
//   out_*     result     out_valid / out_stall action, tx_byte, done_res,
//                                              status, read_value, last
//   APB       config     psel/penable/pready   timeout_limit at byte addr 0
//
// One request per cycle while in_stall is low; each is decoded and its zero
// to three actions go into a four-entry queue that drains one per cycle while
// out_stall is low; in_stall rises when it cannot take a three-action burst.
// Reset is synchronous, active low; the queue empties, phase returns to idle
// and timeout_limit returns to 100000. No clearing pass.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer import i2cras_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_target_addr,
  input  logic [7:0]         in_reg_index,
  input  logic [7:0]         in_data_or_mask,
  input  logic               in_set_bits,
  input  logic               in_start_sent,
  input  logic               in_address_acked,
  input  logic               in_nack_seen,
  input  logic               in_tx_empty,
  input  logic               in_rx_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_action,
  output logic [7:0]         out_tx_byte,
  output logic               out_done_res,
  output logic [1:0]         out_status,
  output logic [7:0]         out_read_value,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [WAIT_W-1:0]  limit_r;
  logic               accept;
  logic               full;
  req_t               req;
  res_t [MAX_RES-1:0] res;
  logic [RESN_W-1:0]  res_n;
  res_t               head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TIMEOUT) ? PDATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT) begin
      limit_r <= pwdata[WAIT_W-1:0];
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  assign req.opcode         = in_opcode;
  assign req.command        = in_command;
  assign req.target_addr    = in_target_addr;
  assign req.reg_index      = in_reg_index;
  assign req.data_or_mask   = in_data_or_mask;
  assign req.set_bits       = in_set_bits;
  assign req.start_sent     = in_start_sent;
  assign req.address_acked  = in_address_acked;
  assign req.nack_seen      = in_nack_seen;
  assign req.tx_empty       = in_tx_empty;
  assign req.rx_ready       = in_rx_ready;
  assign req.rx_byte        = in_rx_byte;

  i2cras_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (req),
    .limit  (limit_r),
    .res    (res),
    .res_n  (res_n)
  );

  i2cras_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_res  (res),
    .push_n    (res_n),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (head)
  );

  assign out_action     = head.action;
  assign out_tx_byte    = head.tx_byte;
  assign out_done_res   = head.done_res;
  assign out_status     = head.status;
  assign out_read_value = head.read_value;
  assign out_last       = head.last;

`ifndef SYNTHESIS
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> out_last)
    else $error("finishing action not last of its request");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_done_res)
    else $error("error status without done");
`endif

endmodule
